// ----- rtl/bba_pkg.sv -----
// Shared types, codes and defaults for the bitmap block allocator.
package bba_pkg;

    // Default sizing
    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 64;

    // Fixed field widths
    localparam int BLOCK_W = 12;
    localparam int TOTAL_W = 13;

    localparam logic [TOTAL_W-1:0] TOTAL_BLOCKS_RESET = 13'd4096;

    // Request codes
    typedef enum logic [1:0] {
        FN_FIND = 2'd0,
        FN_USED = 2'd1,
        FN_FREE = 2'd2
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        func_t              func;
        logic [BLOCK_W-1:0] block_number;
    } req_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] result_block;
        status_t            status;
    } rsp_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_MK_DIV,
        S_MK_FIX,
        S_MK_RD,
        S_MK_WR
    } state_t;

endpackage

// ----- rtl/bba_ram.sv -----
// Generic single-port-write, registered-read RAM.
module bba_ram
    import bba_pkg::*;
#(
    parameter int WIDTH = WORD_BITS_DEF,
    parameter int DEPTH = MAX_BLOCKS_DEF / WORD_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bba_locate.sv -----
// Splits a block number into bitmap word and bit index (reciprocal divide).
module bba_locate
    import bba_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int MAP_WORDS = MAX_BLOCKS_DEF / WORD_BITS_DEF,
    localparam int AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
    localparam int BW       = $clog2(WORD_BITS)
)
(
    input  logic               clk,
    input  logic [BLOCK_W-1:0] blk,
    output logic [AW-1:0]      word,
    output logic [BW-1:0]      bit_idx
);

    localparam int SH    = 24;
    localparam int RECIP = (1 << SH) / WORD_BITS;
    localparam int PRW   = BLOCK_W + SH + 1;
    localparam int PW    = BLOCK_W + 8;

    logic [PRW-1:0]     prod;
    logic [BLOCK_W-1:0] q_reg;
    logic [PW-1:0]      r_raw;
    logic               over;
    logic [BLOCK_W-1:0] q_fix;
    logic [PW-1:0]      r_fix;
    logic [AW-1:0]      word_reg;
    logic [BW-1:0]      bit_reg;

    // Estimate the quotient; it is exact or one low
    assign prod = PRW'(blk) * PRW'(RECIP);

    always_ff @(posedge clk)
    begin
        q_reg <= prod[SH +: BLOCK_W];
    end

    // Correct the estimate with one compare and subtract
    assign r_raw = PW'(blk) - PW'(q_reg) * PW'(WORD_BITS);
    assign over  = (r_raw >= PW'(WORD_BITS));
    assign q_fix = over ? q_reg + BLOCK_W'(1) : q_reg;
    assign r_fix = over ? r_raw - PW'(WORD_BITS) : r_raw;

    always_ff @(posedge clk)
    begin
        word_reg <= AW'(q_fix);
        bit_reg  <= BW'(r_fix);
    end

    assign word    = word_reg;
    assign bit_idx = bit_reg;

endmodule

// ----- rtl/bba_word_search.sv -----
// Finds the lowest free in-range bit of one bitmap word.
module bba_word_search
    import bba_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CW        = 14,
    localparam int BW       = $clog2(WORD_BITS)
)
(
    input  logic [WORD_BITS-1:0] word,
    input  logic [CW-1:0]        remaining,
    output logic                 found,
    output logic [BW-1:0]        bit_idx
);

    logic [WORD_BITS-1:0] free_bits;

    // Treat bits past the block limit as used
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free_bits[b] = !word[b] && (CW'(b) < remaining);
        end
    end

    assign found = |free_bits;

    // Priority pick of the lowest free bit
    always_comb
    begin
        bit_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                bit_idx = BW'(b);
            end
        end
    end

endmodule

// ----- rtl/bitmap_block_allocator.sv -----
// Top level of the bitmap block allocator: sequencer, limit register, bitmap store.
//
// Keeps one usage bit per block (1 = used) in a word-wide RAM of
// MAP_WORDS = ceil(MAX_BLOCKS / WORD_BITS) words. A request is taken when start
// is high and busy is low; its single result appears on rsp for exactly one
// cycle with done high, and must be captured then. A find reads the bitmap
// words in order from word 0 through the registered RAM read into the word
// search, until a free block turns up or the limit is reached (with no read
// at all for a zero block count); mark-used and mark-free run a two-stage
// block-to-word split, a read and a write back; out-of-range marks and the
// unused code answer straight from idle. After reset the block runs a
// clearing pass over all MAP_WORDS words with busy high; total_blocks writes
// are taken during it. Blocks at or above min(total_blocks, MAX_BLOCKS)
// always count as used.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               req,
    output logic               done,
    output rsp_t               rsp,
    input  logic               cfg_wr_en,
    input  logic [TOTAL_W-1:0] cfg_wr_data
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int CW        = $clog2(MAX_BLOCKS + WORD_BITS + 8192);

    state_t               state_reg, state_next;
    logic [TOTAL_W-1:0]   total_reg;
    func_t                func_reg, func_next;
    logic [BLOCK_W-1:0]   blk_reg, blk_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [CW-1:0]        base_reg, base_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [CW-1:0]        total_ext;
    logic [CW-1:0]        limit;
    logic                 req_out_range;
    logic                 accept;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [AW-1:0]        loc_word;
    logic [BW-1:0]        loc_bit;
    logic [WORD_BITS-1:0] bit_mask;

    logic [CW-1:0]        remaining;
    logic                 srch_found;
    logic [BW-1:0]        srch_bit;
    logic [CW-1:0]        hit_block;

    // Effective block limit
    assign total_ext     = CW'(total_reg);
    assign limit         = (total_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : total_ext;
    assign req_out_range = (CW'(req.block_number) >= limit);
    assign accept        = start && (state_reg == S_IDLE);

    assign remaining = limit - base_reg;
    assign hit_block = base_reg + CW'(srch_bit);
    assign bit_mask  = WORD_BITS'(1) << loc_bit;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_locate #(
        .WORD_BITS (WORD_BITS),
        .MAP_WORDS (MAP_WORDS)
    ) u_locate (
        .clk     (clk),
        .blk     (blk_reg),
        .word    (loc_word),
        .bit_idx (loc_bit)
    );

    bba_word_search #(
        .WORD_BITS (WORD_BITS),
        .CW        (CW)
    ) u_search (
        .word      (ram_rdata),
        .remaining (remaining),
        .found     (srch_found),
        .bit_idx   (srch_bit)
    );

    // Block count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_BLOCKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            total_reg <= cfg_wr_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        blk_reg  <= blk_next;
        base_reg <= base_next;
        rsp_reg  <= rsp_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (addr_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == FN_FIND)
                    begin
                        state_next = S_FIND_RD;
                    end
                    else if ((req.func inside {FN_USED, FN_FREE}) && !req_out_range)
                    begin
                        state_next = S_MK_DIV;
                    end
                end
            end
            S_FIND_RD:
            begin
                state_next = (base_reg >= limit) ? S_IDLE : S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                state_next = srch_found ? S_IDLE : S_FIND_RD;
            end
            S_MK_DIV:   state_next = S_MK_FIX;
            S_MK_FIX:   state_next = S_MK_RD;
            S_MK_RD:    state_next = S_MK_WR;
            S_MK_WR:    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath controls and result
    always_comb
    begin
        func_next = func_reg;
        blk_next  = blk_reg;
        addr_next = addr_reg;
        base_next = base_reg;
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = addr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                // Zero one word per cycle
                ram_we    = 1'b1;
                addr_next = addr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = req.func;
                    blk_next  = req.block_number;
                    addr_next = '0;
                    base_next = '0;
                    if ((req.func inside {FN_USED, FN_FREE}) && req_out_range)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{result_block: req.block_number, status: ST_RANGE};
                    end
                    else if (!(req.func inside {FN_FIND, FN_USED, FN_FREE}))
                    begin
                        // Unused code: echo and do nothing
                        done_next = 1'b1;
                        rsp_next  = '{result_block: req.block_number, status: ST_OK};
                    end
                end
            end
            S_FIND_RD:
            begin
                if (base_reg >= limit)
                begin
                    done_next = 1'b1;
                    rsp_next  = '{result_block: '0, status: ST_NONE};
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            S_FIND_CHK:
            begin
                if (srch_found)
                begin
                    done_next = 1'b1;
                    rsp_next  = '{result_block: hit_block[BLOCK_W-1:0], status: ST_OK};
                end
                else
                begin
                    // Advance to the next word
                    addr_next = addr_reg + AW'(1);
                    base_next = base_reg + CW'(WORD_BITS);
                end
            end
            S_MK_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = loc_word;
            end
            S_MK_WR:
            begin
                // Set or clear the block's bit and write back
                ram_we    = 1'b1;
                ram_waddr = loc_word;
                ram_wdata = (func_reg == FN_USED) ? (ram_rdata | bit_mask)
                                                  : (ram_rdata & ~bit_mask);
                done_next = 1'b1;
                rsp_next  = '{result_block: blk_reg, status: ST_OK};
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // The store is written only by the clearing pass or a mark write-back
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_MK_WR))
        else $error("bitmap written outside clear or mark write-back");

    // A find hit never lies at or above the block limit
    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND_CHK && srch_found) |-> (hit_block < limit))
        else $error("find returned a block beyond the limit");

    // Mark write-back only for an in-range block
    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MK_WR) |-> (CW'(blk_reg) < limit))
        else $error("mark write-back for an out-of-range block");

    // The word/bit split recombines to the requested block
    a_locate_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MK_RD)
            |-> ((CW'(loc_word) * CW'(WORD_BITS) + CW'(loc_bit)) == CW'(blk_reg)))
        else $error("block split into word and bit is wrong");

endmodule
